@@ rtl/core/csltp_texture_code_unit_assert.svh @@
// Assertion macros used by the texture code unit checker.
`ifndef CSLTP_TEXTURE_CODE_UNIT_ASSERT_SVH
`define CSLTP_TEXTURE_CODE_UNIT_ASSERT_SVH

// Checked at every rising edge outside reset.
`define CSLTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Checked at every rising edge, reset included.
`define CSLTP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("%m: check failed");

`endif

@@ rtl/core/csltp_pkg.sv @@
// Shared constants, types and helpers of the texture code unit.
package csltp_pkg;

  localparam int MaxWidth  = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int WidthW    = AddrW + 1;
  localparam int HeightW   = 16;
  localparam int PixW      = 8;
  localparam int ThrW      = 8;
  localparam int CodeW     = 7;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegThreshold = 2'd0,
    RegWidth     = 2'd1,
    RegHeight    = 2'd2
  } csltp_reg_e;

  // One result beat
  typedef struct packed {
    logic             last;
    logic [CodeW-1:0] code;
  } csltp_res_t;

  // One window column, top row first
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } csltp_col_t;

  // Ternary digit of a - b against threshold t
  function automatic logic [1:0] csltp_tern(input logic [PixW-1:0] a,
                                            input logic [PixW-1:0] b,
                                            input logic [ThrW-1:0] t);
    logic signed [PixW+1:0] dif;
    logic signed [PixW+1:0] lim;
    dif = $signed({2'b00, a}) - $signed({2'b00, b});
    lim = $signed({2'b00, t});
    if (dif >= lim) begin
      return 2'd2;
    end else if (dif > -lim) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

endpackage

@@ rtl/core/csltp_texture_code_unit.sv @@
// Top level: 3x3 centre-symmetric local ternary pattern over a raster pixel stream.
//
//   channel   | dir | handshake                    | payload
//   ----------+-----+------------------------------+-----------------------------------
//   s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] pixel
//   m_axis    | out | m_axis_tvalid / m_axis_tready | tdata[6:0] pattern_code, tlast frame_last
//   cfg       | in  | cfg_we_i (no stall)          | cfg_idx_i, cfg_data_i
//
// One pixel per clock while s_axis_tready is high; a code passes the stage 1 and stage 2
// registers and the result queue after its pixel is taken. The rate is set by the single
// line-store RAM: read at accept, written back in the cycle after (successive columns never
// share an entry, so no forwarding). s_axis_tready drops only when the 4-entry result queue
// plus codes in flight would overflow. Reset clears counters, window and queue; line stores are
// not cleared and need no clearing pass.
module csltp_texture_code_unit import csltp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Pixel input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] pixel
  // Code output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [6:0] pattern_code, [7] zero
  output logic                m_axis_tlast,   // frame_last
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [ThrW-1:0]    thr_q;
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;

  // Counters
  logic [AddrW-1:0]   col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;

  // Pipeline
  logic                 accept;
  logic [WidthW-1:0]    w_eff;
  logic [HeightW-1:0]   h_eff;
  logic                 row_end, frame_end, emit;
  logic [2*PixW-1:0]    lstore_mem [MaxWidth];
  logic [2*PixW-1:0]    rd_q;
  logic                 s1_valid_q, s1_emit_q, s1_last_q;
  logic [PixW-1:0]      s1_pix_q;
  logic [AddrW-1:0]     s1_addr_q;
  csltp_col_t           new_col, prev1_q, prev2_q;
  logic [3:0][1:0]      dig;
  logic                 s2_valid_q, s2_last_q;
  logic [3:0][1:0]      s2_dig_q;
  csltp_res_t           res;
  csltp_res_t           out_res;
  logic [CntW-1:0]      fifo_cnt;
  logic [CntW:0]        occupancy;

  // Configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrW'(20);
      width_q  <= WidthW'(512);
      height_q <= HeightW'(512);
    end else if (cfg_we_i) begin
      case (csltp_reg_e'(cfg_idx_i))
        RegThreshold: thr_q    <= cfg_data_i[ThrW-1:0];
        RegWidth:     width_q  <= cfg_data_i[WidthW-1:0];
        RegHeight:    height_q <= cfg_data_i[HeightW-1:0];
        default:      ;
      endcase
    end
  end

  // Effective frame size
  always_comb begin
    w_eff = width_q;
    if (width_q < WidthW'(3)) begin
      w_eff = WidthW'(3);
    end else if (width_q > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end
    h_eff = (height_q < HeightW'(3)) ? HeightW'(3) : height_q;
  end

  // Raster position and border test
  assign accept    = s_axis_tvalid & s_axis_tready;
  assign row_end   = (WidthW'(col_q) + WidthW'(1)) >= w_eff;
  assign frame_end = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
  assign emit      = (row_q >= HeightW'(2)) && (col_q >= AddrW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : HeightW'(row_q + 1'b1);
    end else begin
      col_d = AddrW'(col_q + 1'b1);
    end
  end

  // Stage 0 control and stage 1 sideband
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        col_q     <= col_d;
        row_q     <= row_d;
        s1_emit_q <= emit;
        s1_last_q <= row_end & frame_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= s_axis_tdata[PixW-1:0];
      s1_addr_q <= col_q;
    end
  end

  // Line stores: upper byte two rows back, lower byte previous row
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= lstore_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      lstore_mem[s1_addr_q] <= {rd_q[PixW-1:0], s1_pix_q};
    end
  end

  // Window: left column prev2, centre prev1, right the new column
  assign new_col = '{top: rd_q[2*PixW-1:PixW], mid: rd_q[PixW-1:0], bot: s1_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev1_q <= '0;
      prev2_q <= '0;
    end else if (s1_valid_q) begin
      prev1_q <= new_col;
      prev2_q <= prev1_q;
    end
  end

  // Four symmetric pairs
  assign dig[0] = csltp_tern(new_col.mid, prev2_q.mid, thr_q);
  assign dig[1] = csltp_tern(new_col.top, prev2_q.bot, thr_q);
  assign dig[2] = csltp_tern(prev1_q.top, prev1_q.bot, thr_q);
  assign dig[3] = csltp_tern(prev2_q.top, new_col.bot, thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q & s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_dig_q  <= dig;
      s2_last_q <= s1_last_q;
    end
  end

  // Base-3 code
  assign res.code = CodeW'(s2_dig_q[0]) + CodeW'(s2_dig_q[1]) * CodeW'(3)
                  + CodeW'(s2_dig_q[2]) * CodeW'(9) + CodeW'(s2_dig_q[3]) * CodeW'(27);
  assign res.last = s2_last_q;

  csltp_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res),
    .count_o     (fifo_cnt)
  );

  // Reserve a queue slot for every code in flight
  assign occupancy = (CntW+1)'(fifo_cnt) + (CntW+1)'(s1_valid_q & s1_emit_q)
                   + (CntW+1)'(s2_valid_q);
  assign s_axis_tready = occupancy < (CntW+1)'(FifoDepth);

  assign m_axis_tdata = {1'b0, out_res.code};
  assign m_axis_tlast = out_res.last;

endmodule

@@ rtl/core/csltp_ofifo.sv @@
// Small result queue that decouples the code pipeline from the output stream.
module csltp_ofifo import csltp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  csltp_res_t      push_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output csltp_res_t      out_data_o,
  output logic [CntW-1:0] count_o
);

  csltp_res_t            slot_q [FifoDepth];
  logic       [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic       [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic       [CntW-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign count_o     = cnt_q;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop    ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (!push_i && pop) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/csltp_checker.sv @@
// Port-level checker of the texture code unit, bound to the top level.
`include "csltp_texture_code_unit_assert.svh"

module csltp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled beat stays up
  `CSLTP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // A stalled beat keeps its code
  `CSLTP_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

  // A stalled beat keeps its last flag
  `CSLTP_ASSERT(a_last_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))

  // Codes stay in base-3 range with the pad bit clear
  `CSLTP_ASSERT(a_code_range, m_axis_tvalid |-> m_axis_tdata <= 8'd80)

  // Reset leaves the result queue empty
  `CSLTP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid)

endmodule

bind csltp_texture_code_unit csltp_checker u_csltp_checker (.*);
